/* src/pfde_pkg.sv */
`default_nettype none
package pfde_pkg;
   localparam int DISP_W = 128;
   localparam int DISP_H = 64;
   localparam int PAGES = (DISP_H + 7) / 8;
   localparam int DEPTH = DISP_W * PAGES;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DISP_W);
   localparam int PW = $clog2(PAGES);
   localparam logic [7:0] CMD_PAGE = 8'hB0;
   localparam logic [7:0] CMD_COLHI = 8'h10;
   localparam logic [3:0] NIB_MASK = 4'hF;
   localparam logic [7:0] FULL_MASK = 8'hFF;

   typedef enum logic [1:0] {
      REQ_PIXEL = 2'd0,
      REQ_FILL  = 2'd1,
      REQ_EMIT  = 2'd2,
      REQ_BAD   = 2'd3
   } req_type_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_WAIT, ST_WR, ST_CMD, ST_ERD, ST_EWAIT,
      ST_ECAP, ST_EOUT, ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clr_step;
      logic load;
      logic mem_rd;
      logic mem_wr;
      logic next_col;
      logic next_page;
      logic cap_byte;
      logic emit_cmd;
      logic emit_data;
      logic emit_simple;
      logic rsp_take;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic bad;
      logic col_last;
      logic page_last;
      logic lane_full;
      logic rsp_busy;
   } stat_type;
endpackage
`default_nettype wire

/* src/pfde_ctrl.sv */
`default_nettype none
module pfde_ctrl import pfde_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_type,
   input  wire logic         rsp_ready,
   input  wire stat_type     st,
   output cmd_type           cmd
);
   state_type state_ff, state_in;
   req_type_type kind_ff, kind_in;
   req_type_type rt;
   assign rt = req_type_type'(req_type);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff <= REQ_PIXEL;
      end else begin
         state_ff <= state_in;
         kind_ff <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      unique case (state_ff)
         ST_CLEAR: if (st.clr_done) state_in = ST_IDLE;
         ST_IDLE: if (req_valid) begin
            kind_in = rt;
            state_in = ST_RESP;
            if (rt == REQ_PIXEL || rt == REQ_FILL) state_in = ST_RD;
            else if (rt == REQ_EMIT) state_in = ST_CMD;
         end
         ST_RD: state_in = st.bad ? ST_RESP : ST_WAIT;
         ST_WAIT: state_in = ST_WR;
         ST_WR: if (kind_ff == REQ_PIXEL || (st.col_last && st.page_last))
               state_in = ST_RESP;
            else state_in = ST_RD;
         ST_CMD: if (!st.rsp_busy) state_in = st.bad ? ST_IDLE : ST_ERD;
         ST_ERD: state_in = ST_EWAIT;
         ST_EWAIT: state_in = ST_ECAP;
         ST_ECAP: state_in = (st.lane_full || st.col_last) ? ST_EOUT : ST_ERD;
         ST_EOUT: if (!st.rsp_busy) state_in = st.col_last ? ST_IDLE : ST_ERD;
         ST_RESP: if (!st.rsp_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      cmd.rsp_take = rsp_ready;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_RD: cmd.mem_rd = !st.bad;
         ST_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.next_col = 1'b1;
         end
         ST_CMD: cmd.emit_cmd = !st.rsp_busy;
         ST_ERD: cmd.mem_rd = 1'b1;
         ST_ECAP: cmd.cap_byte = 1'b1;
         ST_EOUT: cmd.emit_data = !st.rsp_busy;
         ST_RESP: cmd.emit_simple = !st.rsp_busy;
         default: ;
      endcase
      cmd.next_page = cmd.next_col && st.col_last;
   end
endmodule
`default_nettype wire

/* src/pfde_dp.sv */
`default_nettype none
module pfde_dp import pfde_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   input  wire logic [1:0]   req_type,
   input  wire logic [6:0]   req_x_start,
   input  wire logic [5:0]   req_y_start,
   input  wire logic [6:0]   req_x_end,
   input  wire logic [5:0]   req_y_end,
   input  wire logic         req_colour_on,
   input  wire logic [2:0]   req_page_index,
   input  wire logic [7:0]   req_byte_count,
   output stat_type          st,
   output logic              rsp_valid,
   output logic [63:0]       rsp_payload,
   output logic [3:0]        rsp_valid_bytes,
   output logic              rsp_is_data,
   output logic [2:0]        rsp_first_page,
   output logic [2:0]        rsp_last_page,
   output logic              rsp_error,
   output logic              rsp_last
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_ff;
   logic [AW-1:0] clr_ff;
   logic clr_done_ff;
   req_type_type kind_ff;
   logic [7:0] x0_ff, x1_ff, col_ff;
   logic [6:0] y0_ff, y1_ff;
   logic [2:0] pg_ff, fp_ff, lp_ff;
   logic on_ff, bad_ff;
   logic [7:0] cnt_ff;
   logic [8:0] xe;
   logic [63:0] lane_ff;
   logic [3:0] nb_ff;
   logic [AW-1:0] addr;
   logic [2:0] top, bot;
   logic [7:0] mask;
   logic rv_ff;
   logic [63:0] rp_ff;
   logic [3:0] rb_ff;
   logic rd_ff_d, re_ff, rl_ff;
   logic [2:0] rf_ff, rlp_ff;
   logic bad_in;

   assign xe = {2'b0, req_x_start} + {1'b0, req_byte_count};
   always_comb begin
      unique case (req_type_type'(req_type))
         REQ_PIXEL: bad_in = ({1'b0, req_x_start} >= 8'(DISP_W))
            || ({1'b0, req_y_start} >= 7'(DISP_H));
         REQ_FILL: bad_in = (req_x_start > req_x_end) || (req_y_start > req_y_end)
            || ({1'b0, req_x_end} >= 8'(DISP_W)) || ({1'b0, req_y_end} >= 7'(DISP_H));
         REQ_EMIT: bad_in = (req_byte_count == 8'd0)
            || ({1'b0, req_page_index} >= 4'(PAGES)) || (xe > 9'(DISP_W));
         default: bad_in = 1'b1;
      endcase
   end

   assign addr = AW'({pg_ff, col_ff[CW-1:0]});
   assign top = (pg_ff == y0_ff[5:3]) ? y0_ff[2:0] : 3'd0;
   assign bot = (pg_ff == y1_ff[5:3]) ? y1_ff[2:0] : 3'd7;
   assign mask = (kind_ff == REQ_PIXEL) ? (8'd1 << y0_ff[2:0])
      : ((FULL_MASK << top) & (FULL_MASK >> (3'd7 - bot)));

   always_ff @(posedge clock) begin
      if (!clr_done_ff) mem[clr_ff] <= 8'd0;
      else if (cmd.mem_wr) mem[addr] <= on_ff ? (rd_ff | mask) : (rd_ff & ~mask);
      if (cmd.mem_rd) rd_ff <= mem[addr];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else if (cmd.clr_step && !clr_done_ff) begin
         if (clr_ff == '1) begin
            clr_done_ff <= 1'b1;
         end else clr_ff <= clr_ff + 1'b1;
      end
   end

   assign st.clr_done = clr_done_ff;
   assign st.bad = bad_ff;
   assign st.col_last = (kind_ff == REQ_EMIT) ? (cnt_ff == 8'd1)
      : (col_ff == x1_ff);
   assign st.page_last = (pg_ff == y1_ff[5:3]);
   assign st.lane_full = (nb_ff == 4'd7);
   assign st.rsp_busy = rv_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_type_type'(req_type);
         x0_ff <= {1'b0, req_x_start};
         x1_ff <= {1'b0, req_x_end};
         col_ff <= {1'b0, req_x_start};
         y0_ff <= {1'b0, req_y_start};
         y1_ff <= {1'b0, req_y_start};
         on_ff <= req_colour_on;
         bad_ff <= bad_in;
         cnt_ff <= req_byte_count;
         pg_ff <= (req_type_type'(req_type) == REQ_EMIT) ? req_page_index
            : req_y_start[5:3];
         fp_ff <= req_y_start[5:3];
         lp_ff <= req_y_end[5:3];
         nb_ff <= 4'd0;
         lane_ff <= '0;
         if (req_type_type'(req_type) == REQ_FILL) y1_ff <= {1'b0, req_y_end};
      end else begin
         if (cmd.next_col) begin
            if (cmd.next_page) begin
               col_ff <= x0_ff;
               pg_ff <= pg_ff + 3'd1;
            end else col_ff <= col_ff + 8'd1;
         end
         if (cmd.cap_byte) begin
            lane_ff[nb_ff[2:0]*8 +: 8] <= rd_ff;
            nb_ff <= nb_ff + 4'd1;
            if (!(st.lane_full || st.col_last)) begin
               col_ff <= col_ff + 8'd1;
               cnt_ff <= cnt_ff - 8'd1;
            end
         end
         if (cmd.emit_data) begin
            nb_ff <= 4'd0;
            lane_ff <= '0;
            col_ff <= col_ff + 8'd1;
            cnt_ff <= cnt_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (cmd.emit_cmd || cmd.emit_data || cmd.emit_simple) rv_ff <= 1'b1;
      else if (cmd.rsp_take) rv_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.emit_cmd || cmd.emit_simple) begin
         rp_ff <= '0;
         rb_ff <= 4'd0;
         rd_ff_d <= 1'b0;
         rf_ff <= 3'd0;
         rlp_ff <= 3'd0;
         re_ff <= bad_ff;
         rl_ff <= 1'b1;
         if (!bad_ff && cmd.emit_cmd) begin
            rp_ff <= {40'd0, 4'd0, x0_ff[3:0] & NIB_MASK,
               CMD_COLHI | {5'd0, x0_ff[6:4]}, CMD_PAGE | {5'd0, pg_ff}};
            rb_ff <= 4'd3;
            rl_ff <= 1'b0;
         end
         if (!bad_ff && kind_ff == REQ_FILL) begin
            rf_ff <= fp_ff;
            rlp_ff <= lp_ff;
         end
      end else if (cmd.emit_data) begin
         rp_ff <= lane_ff;
         rb_ff <= nb_ff;
         rd_ff_d <= 1'b1;
         rf_ff <= 3'd0;
         rlp_ff <= 3'd0;
         re_ff <= 1'b0;
         rl_ff <= st.col_last;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_payload = rp_ff;
   assign rsp_valid_bytes = rb_ff;
   assign rsp_is_data = rd_ff_d;
   assign rsp_first_page = rf_ff;
   assign rsp_last_page = rlp_ff;
   assign rsp_error = re_ff;
   assign rsp_last = rl_ff;
endmodule
`default_nettype wire

/* src/page_framebuffer_draw_engine_top.sv */
`default_nettype none
// framebuffer draw engine: 128x64 one-bit display held as 8 pages of 128 column bytes in one
// single-port memory, cleared by a pass over every byte after reset during which no request
// is taken. a pixel or a fill reads, waits and writes each covered byte on the single port;
// an emit sends the command result, then reads, waits for and captures each column byte and
// sends a result per eight bytes or at the last byte. one request is served at a time.
module page_framebuffer_draw_engine_top import pfde_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_type,
   input  wire logic [6:0]   req_x_start,
   input  wire logic [5:0]   req_y_start,
   input  wire logic [6:0]   req_x_end,
   input  wire logic [5:0]   req_y_end,
   input  wire logic         req_colour_on,
   input  wire logic [2:0]   req_page_index,
   input  wire logic [7:0]   req_byte_count,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [63:0]       rsp_payload,
   output logic [3:0]        rsp_valid_bytes,
   output logic              rsp_is_data,
   output logic [2:0]        rsp_first_page,
   output logic [2:0]        rsp_last_page,
   output logic              rsp_error,
   output logic              rsp_last
);
   cmd_type cmd;
   stat_type st;

   pfde_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_type, .rsp_ready, .st, .cmd
   );

   pfde_dp u_dp (
      .clock, .reset, .cmd, .req_type, .req_x_start, .req_y_start, .req_x_end,
      .req_y_end, .req_colour_on, .req_page_index, .req_byte_count, .st,
      .rsp_valid, .rsp_payload, .rsp_valid_bytes, .rsp_is_data, .rsp_first_page,
      .rsp_last_page, .rsp_error, .rsp_last
   );
endmodule
`default_nettype wire
